### sv/cmwc_pkg.sv
// Package for the CMWC lag-4096 random generator.
// Constants, datapath command and status types; no dependencies.
`default_nettype none

package cmwc_pkg;

    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CARRY_W     = 19;
    localparam int unsigned CNT_W       = 64;
    localparam int unsigned MULT_W      = 15;
    localparam int unsigned PROD_W      = 48;
    localparam int unsigned HIGH_W      = PROD_W - WORD_W;

    localparam logic [MULT_W-1:0]  CMWC_MULT  = MULT_W'(18782);
    localparam logic [WORD_W-1:0]  CMWC_BASE  = 32'hffff_fffe;
    localparam logic [WORD_W-1:0]  GOLDEN     = 32'h9e37_79b9;
    localparam logic [CARRY_W-1:0] CARRY_INIT = CARRY_W'(362436);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic clear_wr;
        logic load_seed;
        logic fill_wr;
        logic step;
        logic mult;
        logic wb;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/cmwc_lag4096_random_generator_unit.sv
// Top level of the CMWC lag-4096 random generator.
// Depends on cmwc_pkg, cmwc_ctrl and cmwc_datapath.
//
// Input channel i_valid/o_ready carries i_action and i_seed_value. A draw
// (action 0) gives one transfer on o_valid/i_ready with o_random_word and
// o_draw_count; a reseed (action 1) gives none.
// A draw runs through the single-port lag table as table read, constant
// multiply, then carry correction and write-back. Its result is registered in
// the output register at write-back, and the next item is taken only once the
// unit is back in idle after write-back.
// A reseed fills all 4096 table words and then runs 4096 discarded draws,
// with o_ready low throughout.
// After reset the table is cleared one word a cycle, all 4096 words, with
// o_ready low; carry, index and draw count take their reset values at once.
// The result sits in an output register: the next item is taken while it
// waits, and a draw whose result is ready holds in write-back until the
// receiver has taken the previous one.
`default_nettype none

module cmwc_lag4096_random_generator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_action,
    input  wire logic [cmwc_pkg::WORD_W-1:0]   i_seed_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [cmwc_pkg::WORD_W-1:0]        o_random_word,
    output logic [cmwc_pkg::CNT_W-1:0]         o_draw_count
);
    import cmwc_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    cmwc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd)
    );

    cmwc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_seed_value  (i_seed_value),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_random_word (o_random_word),
        .o_draw_count  (o_draw_count)
    );

endmodule

`default_nettype wire

### sv/cmwc_datapath.sv
// Datapath of the CMWC generator: lag table memory, seed fill, multiply-with-carry.
// Depends on cmwc_pkg; driven by cmwc_ctrl through t_dp_cmd.
`default_nettype none

module cmwc_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cmwc_pkg::t_dp_cmd             i_cmd,
    output cmwc_pkg::t_dp_sts                  o_sts,
    input  wire logic [cmwc_pkg::WORD_W-1:0]   i_seed_value,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic [cmwc_pkg::WORD_W-1:0]        o_random_word,
    output logic [cmwc_pkg::CNT_W-1:0]         o_draw_count
);
    import cmwc_pkg::*;

    logic [WORD_W-1:0]  mem [TABLE_DEPTH];
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_lag_index;
    logic [CARRY_W-1:0] r_carry;
    logic [CNT_W-1:0]   r_draw_counter;
    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_wm1;
    logic [WORD_W-1:0]  r_wm2;
    logic [WORD_W-1:0]  r_wm3;
    logic [WORD_W-1:0]  r_rd_data;
    logic [PROD_W-1:0]  r_t;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [CNT_W-1:0]   r_out_count;

    logic [IDX_W-1:0]   idx_next;
    logic [WORD_W-1:0]  fill_word;
    logic [HIGH_W-1:0]  cy0;
    logic [WORD_W:0]    sum0;
    logic [WORD_W-1:0]  x1;
    logic [CARRY_W-1:0] cy1;
    logic [WORD_W-1:0]  x2;
    logic [CARRY_W-1:0] cy2;
    logic [WORD_W-1:0]  draw_word;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [WORD_W-1:0]  mem_wd;
    logic               cnt_inc;

    assign idx_next = r_lag_index + IDX_W'(1);

    always_comb begin
        if (r_cnt == '0) begin
            fill_word = r_seed;
        end else if (r_cnt == IDX_W'(1) || r_cnt == IDX_W'(2)) begin
            fill_word = r_wm1 + GOLDEN;
        end else begin
            fill_word = r_wm3 ^ r_wm2 ^ GOLDEN ^ {{(WORD_W-IDX_W){1'b0}}, r_cnt};
        end
    end

    // carry corrections: wrapped sum, then all-ones word
    always_comb begin
        cy0  = r_t[PROD_W-1:WORD_W];
        sum0 = {1'b0, r_t[WORD_W-1:0]} + {{(WORD_W+1-HIGH_W){1'b0}}, cy0};
        x1   = sum0[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum0[WORD_W]};
        cy1  = {{(CARRY_W-HIGH_W){1'b0}}, cy0} + {{(CARRY_W-1){1'b0}}, sum0[WORD_W]};
        if (x1 == {WORD_W{1'b1}}) begin
            x2  = '0;
            cy2 = cy1 + CARRY_W'(1);
        end else begin
            x2  = x1;
            cy2 = cy1;
        end
        draw_word = CMWC_BASE - x2;
    end

    always_comb begin
        mem_we = i_cmd.clear_wr | i_cmd.fill_wr | i_cmd.wb;
        mem_wa = i_cmd.wb ? r_lag_index : r_cnt;
        if (i_cmd.wb) begin
            mem_wd = draw_word;
        end else if (i_cmd.fill_wr) begin
            mem_wd = fill_word;
        end else begin
            mem_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_data <= mem[idx_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_t <= PROD_W'(CMWC_MULT) * PROD_W'(r_rd_data)
                   + {{(PROD_W-CARRY_W){1'b0}}, r_carry};
        end
        if (i_cmd.load_seed) begin
            r_seed <= i_seed_value;
        end
        if (i_cmd.fill_wr) begin
            r_wm1 <= fill_word;
            r_wm2 <= r_wm1;
            r_wm3 <= r_wm2;
        end
        if (i_cmd.wb && i_cmd.emit) begin
            r_out_word  <= draw_word;
            r_out_count <= r_draw_counter + CNT_W'(1);
        end
    end

    assign cnt_inc = i_cmd.clear_wr | i_cmd.fill_wr | (i_cmd.wb & ~i_cmd.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt          <= '0;
            r_lag_index    <= '0;
            r_carry        <= CARRY_INIT;
            r_draw_counter <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.load_seed) begin
                r_cnt <= '0;
            end else if (cnt_inc) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (i_cmd.load_seed) begin
                r_lag_index    <= IDX_LAST;
                r_carry        <= CARRY_INIT;
                r_draw_counter <= '0;
            end else begin
                if (i_cmd.step) begin
                    r_lag_index <= idx_next;
                end
                if (i_cmd.wb) begin
                    r_carry <= cy2;
                end
                if (i_cmd.wb && i_cmd.emit) begin
                    r_draw_counter <= r_draw_counter + CNT_W'(1);
                end
            end
            if (i_cmd.wb && i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_last = (r_cnt == IDX_LAST);
    assign o_sts.out_free = ~r_out_valid | i_ready;
    assign o_valid        = r_out_valid;
    assign o_random_word  = r_out_word;
    assign o_draw_count   = r_out_count;

endmodule

`default_nettype wire

### sv/cmwc_ctrl.sv
// Controller of the CMWC generator: table clear, reseed fill, discard draws, draws.
// Depends on cmwc_pkg; drives cmwc_datapath through t_dp_cmd.
`default_nettype none

module cmwc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_action,
    output logic                     o_ready,
    input  wire cmwc_pkg::t_dp_sts   i_sts,
    output cmwc_pkg::t_dp_cmd        o_cmd
);
    import cmwc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_discard;
    logic       n_discard;

    always_comb begin
        n_state   = r_state;
        n_discard = r_discard;
        o_cmd     = '0;
        o_ready   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action) begin
                        o_cmd.load_seed = 1'b1;
                        n_state         = ST_FILL;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_discard  = 1'b0;
                        n_state    = ST_MUL;
                    end
                end
            end
            ST_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_discard = 1'b1;
                    n_state   = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.step = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_WB;
            end
            ST_WB: begin
                if (r_discard) begin
                    o_cmd.wb = 1'b1;
                    n_state  = i_sts.cnt_last ? ST_IDLE : ST_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.wb   = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_discard <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_discard <= n_discard;
        end
    end

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for cmwc_lag4096_random_generator_unit: drives draw and reseed
// transfers, predicts every draw in a scoreboard class and compares word and count.
// Depends on cmwc_pkg and the generator RTL.

typedef struct packed {
    logic [cmwc_pkg::WORD_W-1:0] word;
    logic [cmwc_pkg::CNT_W-1:0]  count;
} t_draw_result;

class t_draw_tracker;
    logic [cmwc_pkg::WORD_W-1:0]  lag_words [cmwc_pkg::TABLE_DEPTH];
    logic [cmwc_pkg::CARRY_W-1:0] carry;
    logic [cmwc_pkg::IDX_W-1:0]   lag_idx;
    logic [cmwc_pkg::CNT_W-1:0]   draws_since_seed;
    t_draw_result                 expected_draws [$];
    int unsigned                  errors;
    int unsigned                  draws_noted;
    int unsigned                  reseeds_noted;

    function new();
        foreach (lag_words[i])
            lag_words[i] = '0;
        carry            = cmwc_pkg::CARRY_INIT;
        lag_idx          = '0;
        draws_since_seed = '0;
        errors           = 0;
        draws_noted      = 0;
        reseeds_noted    = 0;
    endfunction

    function logic [cmwc_pkg::WORD_W-1:0] advance_draw();
        logic [cmwc_pkg::PROD_W-1:0] prod;
        logic [cmwc_pkg::WORD_W-1:0] sum;
        logic [cmwc_pkg::WORD_W-1:0] cy;
        lag_idx = lag_idx + 1'b1;
        prod    = cmwc_pkg::CMWC_MULT * lag_words[lag_idx] + carry;
        cy      = prod[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W];
        sum     = prod[cmwc_pkg::WORD_W-1:0] + cy;
        if (sum < cy) begin
            sum = sum + 1'b1;
            cy  = cy + 1'b1;
        end
        if (sum == '1) begin
            cy  = cy + 1'b1;
            sum = '0;
        end
        carry              = cy[cmwc_pkg::CARRY_W-1:0];
        draws_since_seed   = draws_since_seed + 1'b1;
        sum                = cmwc_pkg::CMWC_BASE - sum;
        lag_words[lag_idx] = sum;
        return sum;
    endfunction

    function void rebuild_table(logic [cmwc_pkg::WORD_W-1:0] seed);
        int unsigned k;
        lag_idx      = cmwc_pkg::IDX_LAST;
        carry        = cmwc_pkg::CARRY_INIT;
        lag_words[0] = seed;
        lag_words[1] = seed + cmwc_pkg::GOLDEN;
        lag_words[2] = lag_words[1] + cmwc_pkg::GOLDEN;
        for (k = 3; k < cmwc_pkg::TABLE_DEPTH; k++)
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ cmwc_pkg::GOLDEN ^ k;
        // discard one full table of draws
        for (k = 0; k < cmwc_pkg::TABLE_DEPTH; k++)
            void'(advance_draw());
        draws_since_seed = '0;
    endfunction

    function void note_transfer(logic is_reseed, logic [cmwc_pkg::WORD_W-1:0] seed);
        t_draw_result want;
        if (is_reseed) begin
            rebuild_table(seed);
            reseeds_noted++;
        end else begin
            want.word  = advance_draw();
            want.count = draws_since_seed;
            expected_draws.push_back(want);
            draws_noted++;
        end
    endfunction

    function void check_draw(logic [cmwc_pkg::WORD_W-1:0] word,
                             logic [cmwc_pkg::CNT_W-1:0] count);
        t_draw_result want;
        if (expected_draws.size() == 0) begin
            $display("%0t: draw result with none expected: word %h count %0d",
                     $time, word, count);
            errors++;
            return;
        end
        want = expected_draws.pop_front();
        if (word !== want.word) begin
            $display("%0t: random_word expected %h actual %h", $time, want.word, word);
            errors++;
        end
        if (count !== want.count) begin
            $display("%0t: draw_count expected %0d actual %0d", $time, want.count, count);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam logic ACT_DRAW          = 1'b0;
    localparam logic ACT_RESEED        = 1'b1;
    localparam int   CYCLE_LIMIT       = 1_500_000;
    localparam int   ITEMS_PER_PHASE   = 200;
    localparam int   RESEEDS_PER_PHASE = 6;
    localparam int   TAIL_CYCLES       = 32;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_action;
    logic [cmwc_pkg::WORD_W-1:0]   i_seed_value;
    logic                          o_valid;
    logic                          i_ready;
    logic [cmwc_pkg::WORD_W-1:0]   o_random_word;
    logic [cmwc_pkg::CNT_W-1:0]    o_draw_count;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               cycles = 0;
    t_draw_tracker    board;

    cmwc_lag4096_random_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_seed_value  (i_seed_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_random_word (o_random_word),
        .o_draw_count  (o_draw_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_draw(o_random_word, o_draw_count);
            if (i_valid && o_ready)
                board.note_transfer(i_action == ACT_RESEED, i_seed_value);
        end
    end

    task automatic push_item(input logic act, input logic [cmwc_pkg::WORD_W-1:0] seed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_action     <= 1'($urandom_range(0, 1));
            i_seed_value <= $urandom();
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_draws.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        int reseeds_left;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        reseeds_left  = RESEEDS_PER_PHASE;
        repeat (ITEMS_PER_PHASE) begin
            if (reseeds_left > 0 && $urandom_range(0, 31) == 0) begin
                reseeds_left--;
                push_item(ACT_RESEED, $urandom());
            end else begin
                push_item(ACT_DRAW, $urandom());
            end
        end
        drain_results();
    endtask

    initial begin
        board = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_action     <= ACT_DRAW;
        i_seed_value <= '0;
        i_ready      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 87;
        // draws on the cleared table before any reseed
        push_item(ACT_DRAW, 32'hffff_ffff);
        push_item(ACT_DRAW, $urandom());
        push_item(ACT_DRAW, 32'h0000_0000);
        push_item(ACT_RESEED, 32'h0000_0000);
        repeat (3) push_item(ACT_DRAW, $urandom());
        push_item(ACT_RESEED, 32'hffff_ffff);
        repeat (2) push_item(ACT_DRAW, $urandom());
        // second table word wraps to zero
        push_item(ACT_RESEED, 32'h61c8_8647);
        repeat (2) push_item(ACT_DRAW, $urandom());
        push_item(ACT_RESEED, cmwc_pkg::GOLDEN);
        push_item(ACT_DRAW, $urandom());
        push_item(ACT_RESEED, $urandom());
        push_item(ACT_RESEED, $urandom());
        repeat (2) push_item(ACT_DRAW, $urandom());
        drain_results();

        random_phase(12, 87);
        random_phase(87, 12);
        random_phase(0, 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.expected_draws.size() != 0) begin
            $display("%0t: pending draw results expected 0 actual %0d",
                     $time, board.expected_draws.size());
            board.errors++;
        end

        $display("Checked %0d draws across %0d reseeds, starting from the cleared table,",
                 board.draws_noted, board.reseeds_noted);
        $display("under sender-heavy, receiver-heavy and stall-free handshake mixes");
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
